>>> rtl/rrf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rrf_pkg;

  localparam int SCREEN_COLS_DEF   = 800;
  localparam int SCREEN_ROWS_DEF   = 480;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int COL_W      = 10;
  localparam int ROW_W      = 9;
  localparam int CENTER_W   = 27;
  localparam int STEP_W     = 25;
  localparam int EXT_W      = 25;
  localparam int COLOR_W    = 16;
  localparam int ADDR_W     = 19;
  localparam int LOCAL_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_COL_X      = 3'd0,
    REG_STEP_COL_Y      = 3'd1,
    REG_STEP_ROW_X      = 3'd2,
    REG_STEP_ROW_Y      = 3'd3,
    REG_HALF_WIDTH      = 3'd4,
    REG_HALF_HEIGHT     = 3'd5,
    REG_BOUNDING_RADIUS = 3'd6,
    REG_FILL_COLOR      = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    B_RUN,
    B_DX,
    B_MUL,
    B_ACC,
    B_FIN
  } back_state_t;

  typedef struct packed {
    logic                       op;
    logic                       empty;
    logic signed [CENTER_W-1:0] cx;
    logic signed [CENTER_W-1:0] cy;
    logic [COL_W-1:0]           col_first;
    logic [COL_W-1:0]           col_end;
    logic [ROW_W-1:0]           row_first;
    logic [ROW_W-1:0]           row_end;
  } rrf_item_t;

  typedef struct packed {
    logic signed [STEP_W-1:0] step_col_x;
    logic signed [STEP_W-1:0] step_col_y;
    logic signed [STEP_W-1:0] step_row_x;
    logic signed [STEP_W-1:0] step_row_y;
    logic [EXT_W-1:0]         half_width;
    logic [EXT_W-1:0]         half_height;
    logic [COLOR_W-1:0]       fill_color;
  } rrf_cfg_t;

  typedef struct packed {
    logic active;
    logic seq_busy;
  } rrf_status_t;

  typedef struct packed {
    logic full;
    logic empty;
  } rrf_qstat_t;

endpackage

`default_nettype wire

>>> rtl/rrf_front.sv
`timescale 1ns / 1ps
`default_nettype none

module rrf_front
  import rrf_pkg::*;
#(
  parameter int SCREEN_COLS   = SCREEN_COLS_DEF,
  parameter int SCREEN_ROWS   = SCREEN_ROWS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                       op,
  input  logic signed [CENTER_W-1:0] center_x,
  input  logic signed [CENTER_W-1:0] center_y,
  input  logic [EXT_W-1:0]           radius,
  output rrf_item_t                  item
);

  localparam int EDGE_W = CENTER_W + 1;
  localparam int INT_W  = EDGE_W - FRACTION_BITS;
  localparam int CMP_W  = (INT_W > COL_W ? INT_W : COL_W) + 1;

  logic signed [EDGE_W-1:0] r_s;
  logic signed [EDGE_W-1:0] lo_x, hi_x, lo_y, hi_y;
  logic [CMP_W-1:0]         si, ei, sj, ej;
  logic [CMP_W-1:0]         hi_x_int, hi_y_int;

  // integer part, negative edges count as zero
  function automatic logic [CMP_W-1:0] int_part(input logic signed [EDGE_W-1:0] v);
    logic [INT_W-1:0] ip;
    ip = v[EDGE_W-1:FRACTION_BITS];
    return v[EDGE_W-1] ? '0 : CMP_W'(ip);
  endfunction

  assign r_s  = $signed({{(EDGE_W-EXT_W){1'b0}}, radius});
  assign lo_x = EDGE_W'(center_x) - r_s;
  assign hi_x = EDGE_W'(center_x) + r_s;
  assign lo_y = EDGE_W'(center_y) - r_s;
  assign hi_y = EDGE_W'(center_y) + r_s;

  always_comb begin
    si       = int_part(lo_x);
    sj       = int_part(lo_y);
    hi_x_int = int_part(hi_x);
    hi_y_int = int_part(hi_y);
    ei       = (hi_x_int > CMP_W'(SCREEN_COLS)) ? CMP_W'(SCREEN_COLS) : hi_x_int;
    ej       = (hi_y_int > CMP_W'(SCREEN_ROWS)) ? CMP_W'(SCREEN_ROWS) : hi_y_int;

    item.op        = op;
    item.empty     = (si >= ei) || (sj >= ej);
    item.cx        = center_x;
    item.cy        = center_y;
    item.col_first = si[COL_W-1:0];
    item.col_end   = ei[COL_W-1:0];
    item.row_first = sj[ROW_W-1:0];
    item.row_end   = ej[ROW_W-1:0];
  end

endmodule

`default_nettype wire

>>> rtl/rrf_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module rrf_queue
  import rrf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  rrf_item_t  push_item,
  input  logic       pop,
  output rrf_item_t  head,
  output rrf_qstat_t qstat
);

  rrf_item_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign head        = mem_r[rd_ptr_r];
  assign qstat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (count_r == '0);

endmodule

`default_nettype wire

>>> rtl/rrf_back.sv
`timescale 1ns / 1ps
`default_nettype none

module rrf_back
  import rrf_pkg::*;
#(
  parameter int SCREEN_COLS   = SCREEN_COLS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rrf_cfg_t           cfg,
  input  rrf_item_t          q_item,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_write_valid,
  output logic [ADDR_W-1:0]  out_address,
  output logic [COLOR_W-1:0] out_color,
  output logic               out_done,
  output rrf_status_t        status
);

  localparam int DX_W   = ((COL_W + FRACTION_BITS) > CENTER_W ?
                           (COL_W + FRACTION_BITS) : CENTER_W) + 2;
  localparam int PROD_W = DX_W + STEP_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int BASE_W = ROW_W + COL_W;
  localparam logic [ACC_W-1:0] FRAC_MASK = (ACC_W'(1) << FRACTION_BITS) - ACC_W'(1);

  back_state_t state_r, state_nxt;

  logic                       active_r, active_nxt;
  logic [COL_W-1:0]           col_now_r, col_now_nxt;
  logic [COL_W-1:0]           col_first_r, col_first_nxt;
  logic [COL_W-1:0]           col_end_r, col_end_nxt;
  logic [ROW_W-1:0]           row_now_r, row_now_nxt;
  logic [ROW_W-1:0]           row_end_r, row_end_nxt;
  logic [BASE_W-1:0]          base_r, base_nxt;
  logic [LOCAL_W-1:0]         local_x_r, local_x_nxt;
  logic [LOCAL_W-1:0]         local_y_r, local_y_nxt;
  logic [LOCAL_W-1:0]         rsx_r, rsx_nxt;
  logic [LOCAL_W-1:0]         rsy_r, rsy_nxt;
  logic signed [CENTER_W-1:0] cx_r, cx_nxt;
  logic signed [CENTER_W-1:0] cy_r, cy_nxt;
  logic signed [DX_W-1:0]     dx_r, dx_nxt;
  logic signed [DX_W-1:0]     dy_r, dy_nxt;
  logic [1:0]                 k_r, k_nxt;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [ACC_W-1:0]    acc_x_r, acc_x_nxt;
  logic signed [ACC_W-1:0]    acc_y_r, acc_y_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic                       out_wv_r, out_wv_nxt;
  logic [ADDR_W-1:0]          out_addr_r, out_addr_nxt;
  logic [COLOR_W-1:0]         out_color_r, out_color_nxt;
  logic                       out_done_r, out_done_nxt;

  logic                       can_out;
  logic                       pop;
  logic signed [DX_W-1:0]     col_fix, row_fix;
  logic signed [DX_W-1:0]     mul_a;
  logic signed [STEP_W-1:0]   mul_b;
  logic signed [LOCAL_W:0]    x_s, y_s, hw_s, hh_s;
  logic                       pix_hit;
  logic [COL_W-1:0]           col_inc;
  logic [ROW_W-1:0]           row_inc;
  logic                       row_wrap;
  logic                       box_last;
  logic [LOCAL_W-1:0]         rsx_step, rsy_step;
  logic [LOCAL_W-1:0]         start_x, start_y;

  function automatic logic [LOCAL_W-1:0] step32(input logic signed [STEP_W-1:0] s);
    return LOCAL_W'(s);
  endfunction

  // shift right rounding toward zero, keep 32 bits
  function automatic logic [LOCAL_W-1:0] trunc_fix(input logic signed [ACC_W-1:0] a);
    logic [ACC_W-1:0] adj;
    adj = a + (a[ACC_W-1] ? FRAC_MASK : '0);
    return adj[FRACTION_BITS +: LOCAL_W];
  endfunction

  assign can_out = !out_valid_r || out_ready;
  assign pop     = (state_r == B_RUN) && can_out && !q_empty;

  assign col_fix = $signed(DX_W'({col_first_r, {FRACTION_BITS{1'b0}}}));
  assign row_fix = $signed(DX_W'({row_now_r, {FRACTION_BITS{1'b0}}}));

  assign mul_a = k_r[0] ? dy_r : dx_r;
  always_comb begin
    case (k_r)
      2'd0:    mul_b = cfg.step_col_x;
      2'd1:    mul_b = cfg.step_row_x;
      2'd2:    mul_b = cfg.step_col_y;
      default: mul_b = cfg.step_row_y;
    endcase
  end

  assign x_s     = $signed({local_x_r[LOCAL_W-1], local_x_r});
  assign y_s     = $signed({local_y_r[LOCAL_W-1], local_y_r});
  assign hw_s    = $signed({{(LOCAL_W+1-EXT_W){1'b0}}, cfg.half_width});
  assign hh_s    = $signed({{(LOCAL_W+1-EXT_W){1'b0}}, cfg.half_height});
  assign pix_hit = (x_s >= -hw_s) && (x_s <= hw_s) && (y_s >= -hh_s) && (y_s <= hh_s);

  assign col_inc  = col_now_r + COL_W'(1);
  assign row_inc  = row_now_r + ROW_W'(1);
  assign row_wrap = (col_inc >= col_end_r);
  assign box_last = row_wrap && (row_inc >= row_end_r);
  assign rsx_step = rsx_r + step32(cfg.step_row_x);
  assign rsy_step = rsy_r + step32(cfg.step_row_y);
  assign start_x  = trunc_fix(acc_x_r);
  assign start_y  = trunc_fix(acc_y_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_RUN: begin
        if (pop && (q_item.op == OP_START) && !q_item.empty) begin
          state_nxt = B_DX;
        end
      end
      B_DX:  state_nxt = B_MUL;
      B_MUL: begin
        if (k_r == 2'd3) begin
          state_nxt = B_ACC;
        end
      end
      B_ACC: state_nxt = B_FIN;
      B_FIN: begin
        if (can_out) begin
          state_nxt = B_RUN;
        end
      end
      default: state_nxt = B_RUN;
    endcase
  end

  always_comb begin
    active_nxt    = active_r;
    col_now_nxt   = col_now_r;
    col_first_nxt = col_first_r;
    col_end_nxt   = col_end_r;
    row_now_nxt   = row_now_r;
    row_end_nxt   = row_end_r;
    base_nxt      = base_r;
    local_x_nxt   = local_x_r;
    local_y_nxt   = local_y_r;
    rsx_nxt       = rsx_r;
    rsy_nxt       = rsy_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    k_nxt         = k_r;
    prod_nxt      = prod_r;
    acc_x_nxt     = acc_x_r;
    acc_y_nxt     = acc_y_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_wv_nxt    = out_wv_r;
    out_addr_nxt  = out_addr_r;
    out_color_nxt = out_color_r;
    out_done_nxt  = out_done_r;

    unique case (state_r)
      B_RUN: begin
        if (pop) begin
          if (q_item.op == OP_START) begin
            if (q_item.empty) begin
              active_nxt    = 1'b0;
              out_valid_nxt = 1'b1;
              out_wv_nxt    = 1'b0;
              out_addr_nxt  = '0;
              out_color_nxt = cfg.fill_color;
              out_done_nxt  = 1'b1;
            end else begin
              col_first_nxt = q_item.col_first;
              col_now_nxt   = q_item.col_first;
              col_end_nxt   = q_item.col_end;
              row_now_nxt   = q_item.row_first;
              row_end_nxt   = q_item.row_end;
              cx_nxt        = q_item.cx;
              cy_nxt        = q_item.cy;
            end
          end else begin
            out_valid_nxt = 1'b1;
            out_color_nxt = cfg.fill_color;
            if (!active_r) begin
              out_wv_nxt   = 1'b0;
              out_addr_nxt = '0;
              out_done_nxt = 1'b1;
            end else begin
              out_wv_nxt   = pix_hit;
              out_addr_nxt = ADDR_W'(base_r + BASE_W'(col_now_r));
              out_done_nxt = box_last;
              if (row_wrap) begin
                col_now_nxt = col_first_r;
                row_now_nxt = row_inc;
                base_nxt    = base_r + BASE_W'(SCREEN_COLS);
                rsx_nxt     = rsx_step;
                rsy_nxt     = rsy_step;
                local_x_nxt = rsx_step;
                local_y_nxt = rsy_step;
                active_nxt  = !box_last;
              end else begin
                col_now_nxt = col_inc;
                local_x_nxt = local_x_r + step32(cfg.step_col_x);
                local_y_nxt = local_y_r + step32(cfg.step_col_y);
              end
            end
          end
        end
      end
      B_DX: begin
        dx_nxt    = col_fix - DX_W'(cx_r);
        dy_nxt    = row_fix - DX_W'(cy_r);
        base_nxt  = BASE_W'(row_now_r) * BASE_W'(SCREEN_COLS);
        k_nxt     = 2'd0;
        acc_x_nxt = '0;
        acc_y_nxt = '0;
      end
      B_MUL: begin
        prod_nxt = mul_a * mul_b;
        k_nxt    = k_r + 2'd1;
        // accumulate the product formed in the previous cycle
        if (k_r == 2'd1 || k_r == 2'd2) begin
          acc_x_nxt = acc_x_r + ACC_W'(prod_r);
        end else if (k_r == 2'd3) begin
          acc_y_nxt = acc_y_r + ACC_W'(prod_r);
        end
      end
      B_ACC: begin
        acc_y_nxt = acc_y_r + ACC_W'(prod_r);
      end
      B_FIN: begin
        if (can_out) begin
          rsx_nxt       = start_x;
          rsy_nxt       = start_y;
          local_x_nxt   = start_x;
          local_y_nxt   = start_y;
          active_nxt    = 1'b1;
          out_valid_nxt = 1'b1;
          out_wv_nxt    = 1'b0;
          out_addr_nxt  = '0;
          out_color_nxt = cfg.fill_color;
          out_done_nxt  = 1'b0;
        end
      end
      default: begin
        active_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_RUN;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_now_r   <= col_now_nxt;
    col_first_r <= col_first_nxt;
    col_end_r   <= col_end_nxt;
    row_now_r   <= row_now_nxt;
    row_end_r   <= row_end_nxt;
    base_r      <= base_nxt;
    local_x_r   <= local_x_nxt;
    local_y_r   <= local_y_nxt;
    rsx_r       <= rsx_nxt;
    rsy_r       <= rsy_nxt;
    cx_r        <= cx_nxt;
    cy_r        <= cy_nxt;
    dx_r        <= dx_nxt;
    dy_r        <= dy_nxt;
    prod_r      <= prod_nxt;
    acc_x_r     <= acc_x_nxt;
    acc_y_r     <= acc_y_nxt;
    out_wv_r    <= out_wv_nxt;
    out_addr_r  <= out_addr_nxt;
    out_color_r <= out_color_nxt;
    out_done_r  <= out_done_nxt;
  end

  assign q_pop           = pop;
  assign out_valid       = out_valid_r;
  assign out_write_valid = out_wv_r;
  assign out_address     = out_addr_r;
  assign out_color       = out_color_r;
  assign out_done        = out_done_r;
  assign status.active   = active_r;
  assign status.seq_busy = (state_r != B_RUN);

endmodule

`default_nettype wire

>>> rtl/rotated_rectangle_fill_top.sv
// channel   dir  handshake              tdata (low bit up)                 tuser / tlast
// in_       in   in_tvalid/in_tready    center_x[26:0], center_y[53:27]    tuser = op
// out_      out  out_tvalid/out_tready  pixel_address[18:0], color[34:19]  tuser = write_valid,
//                                                                          tlast = done_res
// cfg_      in   cfg_we                 cfg_index selects, cfg_data        -
//
// ticks and empty-box starts pass one item per cycle unless out_tready or a start holds them
// a start with a non-empty box holds the back end in B_DX, B_MUL, B_ACC, B_FIN: one shared
// multiplier forms the four offset products in turn, then an add and a rounding shift
// the two-entry queue keeps taking items until full while the back end or out_tready stalls
// rst_n is synchronous, active low; only control and config registers take reset values
`timescale 1ns / 1ps
`default_nettype none

module rotated_rectangle_fill_top
  import rrf_pkg::*;
#(
  parameter int SCREEN_COLS   = SCREEN_COLS_DEF,
  parameter int SCREEN_ROWS   = SCREEN_ROWS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [55:0]           in_tdata,   // center_x, center_y, zero pad
  input  logic                  in_tuser,   // op
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [39:0]           out_tdata,  // pixel_address, pixel_color, zero pad
  output logic                  out_tuser,  // write_valid
  output logic                  out_tlast,  // done_res
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  rrf_cfg_t           cfg_r;
  logic [EXT_W-1:0]   radius_r;
  rrf_item_t          front_item;
  rrf_item_t          q_head;
  rrf_qstat_t         qstat;
  rrf_status_t        status;
  logic               q_push;
  logic               q_pop;
  logic [ADDR_W-1:0]  out_address;
  logic [COLOR_W-1:0] out_color;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_col_x  <= STEP_W'(1 << FRACTION_BITS);
      cfg_r.step_col_y  <= '0;
      cfg_r.step_row_x  <= '0;
      cfg_r.step_row_y  <= STEP_W'(1 << FRACTION_BITS);
      cfg_r.half_width  <= '0;
      cfg_r.half_height <= '0;
      cfg_r.fill_color  <= '0;
      radius_r          <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_STEP_COL_X:      cfg_r.step_col_x  <= $signed(cfg_data);
        REG_STEP_COL_Y:      cfg_r.step_col_y  <= $signed(cfg_data);
        REG_STEP_ROW_X:      cfg_r.step_row_x  <= $signed(cfg_data);
        REG_STEP_ROW_Y:      cfg_r.step_row_y  <= $signed(cfg_data);
        REG_HALF_WIDTH:      cfg_r.half_width  <= cfg_data;
        REG_HALF_HEIGHT:     cfg_r.half_height <= cfg_data;
        REG_BOUNDING_RADIUS: radius_r          <= cfg_data;
        REG_FILL_COLOR:      cfg_r.fill_color  <= cfg_data[COLOR_W-1:0];
        default:             radius_r          <= radius_r;
      endcase
    end
  end

  assign in_tready = !qstat.full;
  assign q_push    = in_tvalid && in_tready;

  rrf_front #(
    .SCREEN_COLS  (SCREEN_COLS),
    .SCREEN_ROWS  (SCREEN_ROWS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_front (
    .op      (in_tuser),
    .center_x($signed(in_tdata[CENTER_W-1:0])),
    .center_y($signed(in_tdata[2*CENTER_W-1:CENTER_W])),
    .radius  (radius_r),
    .item    (front_item)
  );

  rrf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_item(front_item),
    .pop      (q_pop),
    .head     (q_head),
    .qstat    (qstat)
  );

  rrf_back #(
    .SCREEN_COLS  (SCREEN_COLS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_item         (q_head),
    .q_empty        (qstat.empty),
    .q_pop          (q_pop),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_write_valid(out_tuser),
    .out_address    (out_address),
    .out_color      (out_color),
    .out_done       (out_tlast),
    .status         (status)
  );

  assign out_tdata = {{(40-ADDR_W-COLOR_W){1'b0}}, out_color, out_address};

`ifndef NO_ASSERTIONS
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !qstat.empty)
    else $error("queue popped while empty");

  a_no_pop_in_seq: assert property (@(posedge clk) disable iff (!rst_n)
    status.seq_busy |-> !q_pop)
    else $error("queue popped during start sequence");

  a_write_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (32'(out_address) < SCREEN_COLS * SCREEN_ROWS))
    else $error("pixel write outside screen");

  a_box_opens_with_start_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(status.active) |-> (out_tvalid && !out_tlast))
    else $error("box opened without its start item");
`endif

endmodule

`default_nettype wire
